@@ sv/tga_rle_pixel_decoder_assert.svh @@
// Assertion macros used by the decoder's checker.
`ifndef TGA_RLE_PIXEL_DECODER_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_ASSERT_SVH

// Same-cycle implication, quiet while reset is high.
`define TRD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed in %m");

// Next-cycle implication, quiet while reset is high.
`define TRD_ASSERT_NEXT(lbl, clk, ante, cons, rst) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed in %m");

// Next-cycle implication that also watches through reset.
`define TRD_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("check failed in %m");

`endif

@@ sv/trd_pkg.sv @@
// Types, codes and constants of the TGA run-length pixel decoder.
`default_nettype none

package trd_pkg;

   localparam int unsigned MAX_BYTES_PER_PIXEL = 4;
   localparam int unsigned PIXEL_W             = 8 * MAX_BYTES_PER_PIXEL;
   localparam int unsigned COUNT_W             = 32;
   localparam int unsigned BPP_W               = 3;
   localparam int unsigned CSR_INDEX_W         = 4;
   localparam int unsigned CSR_DATA_W          = 32;

   localparam logic [7:0] RUN_THRESHOLD = 8'd128;
   localparam logic [7:0] RUN_BIAS      = 8'd127;

   localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd3;
   localparam logic [COUNT_W-1:0] TOTAL_RESET = 32'd1;

   localparam logic [CSR_INDEX_W-1:0] CSR_BYTES_PER_PIXEL = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_TOTAL     = 4'd1;

   typedef enum logic {
      OP_DATA  = 1'b0,
      OP_START = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_RAW    = 3'd1,
      PH_RUN    = 3'd2,
      PH_DONE   = 3'd3,
      PH_ERROR  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_TOO_MANY = 2'd1,
      ST_IGNORED  = 2'd2
   } rsp_status_type;

   typedef enum logic {
      CTL_IDLE   = 1'b0,
      CTL_EXPAND = 1'b1
   } ctl_state_type;

   // Controller to datapath.
   typedef struct packed {
      logic accept;      // take the request on the port
      logic emit;        // load one result into the output register
      logic from_input;  // the pixel of this result includes the request byte
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic needs_result;  // the offered request causes at least one result
      logic out_free;      // output register can take a result this cycle
      logic step_last;     // the result built this cycle ends its request
   } stat_type;

endpackage

`default_nettype wire

@@ sv/trd_ifs.sv @@
// Channel interfaces of the decoder: request, result and register write.
`default_nettype none

interface trd_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] data_byte;

   modport source (output valid, output op, output data_byte, input ready);
   modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface trd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [trd_pkg::PIXEL_W-1:0] pixel_first;
   logic [trd_pkg::PIXEL_W-1:0] pixel_second;
   logic [1:0]                  pixel_count;
   logic [1:0]                  status;
   logic                        image_done;
   logic                        last;

   modport source (output valid, output pixel_first, output pixel_second,
                   output pixel_count, output status, output image_done,
                   output last, input ready);
   modport sink   (input valid, input pixel_first, input pixel_second,
                   input pixel_count, input status, input image_done,
                   input last, output ready);
endinterface

interface trd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [trd_pkg::CSR_INDEX_W-1:0] index;
   logic [trd_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/tga_rle_pixel_decoder.sv @@
// Top level of the TGA run-length pixel decoder.
//
//   channel  dir  payload                                    accepted when
//   req_ch   in   op, data_byte                              valid && ready
//   rsp_ch   out  pixel_first/second, pixel_count, status,   valid && ready
//                 image_done, last
//   csr_ch   in   index (0 bytes_per_pixel, 1 pixel_total),  valid && ready
//                 data
//
// A start, header or partial-pixel request yields no result.
// A byte that completes a pixel yields one result per cycle while the output
// is not stalled, through the single output register: raw pixels one each, a
// run of n copies ceil(n/2) results (pixels paired), while the next request waits.
// A request may be taken while a result waits; one that needs the output waits
// in the expansion state until the register frees. The register port is
// always ready. Synchronous reset clears control; no clearing pass.
`default_nettype none

module tga_rle_pixel_decoder (
   input  wire logic  clock,
   input  wire logic  reset,
   trd_req_if.sink    req_ch,
   trd_rsp_if.source  rsp_ch,
   trd_csr_if.sink    csr_ch
);

   trd_pkg::cmd_type  cmd;
   trd_pkg::stat_type stat;
   logic              csr_fire;

   // registers are written in the cycle the write is offered
   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid;

   // controller: decides when a request is taken and when a result is loaded
   trd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .stat      (stat),
      .cmd       (cmd),
      .req_ready (req_ch.ready)
   );

   // datapath: packet and pixel state, count against the total, output register
   trd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_op           (req_ch.op),
      .req_data_byte    (req_ch.data_byte),
      .csr_fire         (csr_fire),
      .csr_index        (csr_ch.index),
      .csr_data         (csr_ch.data),
      .rsp_ready        (rsp_ch.ready),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_ch.valid),
      .rsp_pixel_first  (rsp_ch.pixel_first),
      .rsp_pixel_second (rsp_ch.pixel_second),
      .rsp_pixel_count  (rsp_ch.pixel_count),
      .rsp_status       (rsp_ch.status),
      .rsp_image_done   (rsp_ch.image_done),
      .rsp_last         (rsp_ch.last)
   );

endmodule

`default_nettype wire

@@ sv/trd_ctrl.sv @@
// Controller: takes requests and sequences the results of a run.
`default_nettype none

module trd_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire trd_pkg::stat_type stat,
   output trd_pkg::cmd_type       cmd,
   output logic                   req_ready
);

   trd_pkg::ctl_state_type state_ff;
   trd_pkg::ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= trd_pkg::CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd.accept     = 1'b0;
      cmd.emit       = 1'b0;
      cmd.from_input = 1'b0;
      req_ready      = 1'b0;
      unique case (state_ff)
         trd_pkg::CTL_IDLE: begin
            req_ready      = 1'b1;
            cmd.from_input = 1'b1;
            cmd.accept     = req_valid;
            if (req_valid && stat.needs_result) begin
               // emit straight away when the slot is free, else hold for later
               cmd.emit = stat.out_free;
               if (!(stat.out_free && stat.step_last)) begin
                  state_in = trd_pkg::CTL_EXPAND;
               end
            end
         end
         trd_pkg::CTL_EXPAND: begin
            cmd.emit = stat.out_free;
            if (stat.out_free && stat.step_last) begin
               state_in = trd_pkg::CTL_IDLE;
            end
         end
         default: begin
            state_in = trd_pkg::CTL_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ sv/trd_datapath.sv @@
// Datapath: packet state, pixel assembly, pixel count and output register.
`default_nettype none

module trd_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_op,
   input  wire logic [7:0]                      req_data_byte,
   input  wire logic                            csr_fire,
   input  wire logic [trd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [trd_pkg::CSR_DATA_W-1:0]  csr_data,
   input  wire logic                            rsp_ready,
   input  wire trd_pkg::cmd_type                cmd,
   output trd_pkg::stat_type                    stat,
   output logic                                 rsp_valid,
   output logic [trd_pkg::PIXEL_W-1:0]          rsp_pixel_first,
   output logic [trd_pkg::PIXEL_W-1:0]          rsp_pixel_second,
   output logic [1:0]                           rsp_pixel_count,
   output logic [1:0]                           rsp_status,
   output logic                                 rsp_image_done,
   output logic                                 rsp_last
);

   // configuration
   logic [trd_pkg::BPP_W-1:0]   bpp_ff, bpp_in;
   logic [trd_pkg::COUNT_W-1:0] total_ff, total_in;

   // decode state
   trd_pkg::phase_type          phase_ff, phase_in;
   logic [7:0]                  rem_ff, rem_in;
   logic [1:0]                  bip_ff, bip_in;
   logic [trd_pkg::PIXEL_W-1:0] asm_ff, asm_in;
   logic [trd_pkg::COUNT_W-1:0] emitted_ff, emitted_in;

   // output register
   logic                        out_valid_ff, out_valid_in;
   logic [trd_pkg::PIXEL_W-1:0] out_first_ff, out_first_in;
   logic [trd_pkg::PIXEL_W-1:0] out_second_ff, out_second_in;
   logic [1:0]                  out_count_ff, out_count_in;
   trd_pkg::rsp_status_type     out_status_ff, out_status_in;
   logic                        out_done_ff, out_done_in;
   logic                        out_last_ff, out_last_in;

   logic [trd_pkg::BPP_W-1:0]   pixel_size;
   logic                        byte_done;
   logic                        in_packet;
   logic                        halted;
   logic [trd_pkg::PIXEL_W-1:0] pixel_now;
   logic [trd_pkg::PIXEL_W-1:0] pix;

   // one result step
   logic [trd_pkg::COUNT_W-1:0] e1, e2;
   logic [7:0]                  r1, r2;
   logic                        over, eq1, eq2;
   trd_pkg::phase_type          st_phase;
   logic [7:0]                  st_rem;
   logic [trd_pkg::COUNT_W-1:0] st_emitted;
   logic [trd_pkg::PIXEL_W-1:0] st_first, st_second;
   logic [1:0]                  st_count;
   trd_pkg::rsp_status_type     st_status;
   logic                        st_done, st_last;

   always_comb begin
      if (bpp_ff == '0) begin
         pixel_size = 3'd1;
      end else if (bpp_ff > trd_pkg::BPP_W'(trd_pkg::MAX_BYTES_PER_PIXEL)) begin
         pixel_size = trd_pkg::BPP_W'(trd_pkg::MAX_BYTES_PER_PIXEL);
      end else begin
         pixel_size = bpp_ff;
      end
   end

   assign byte_done = ({1'b0, bip_ff} + 3'd1) >= pixel_size;
   assign in_packet = (phase_ff == trd_pkg::PH_RAW) || (phase_ff == trd_pkg::PH_RUN);
   assign halted    = (phase_ff == trd_pkg::PH_DONE) || (phase_ff == trd_pkg::PH_ERROR);
   assign pixel_now = asm_ff
                    | (trd_pkg::PIXEL_W'(req_data_byte) << {bip_ff, 3'b000});
   assign pix       = cmd.from_input ? pixel_now : asm_ff;

   assign stat.needs_result = (req_op == trd_pkg::OP_DATA)
                            && (halted || (in_packet && byte_done));
   assign stat.out_free     = !out_valid_ff || rsp_ready;
   assign stat.step_last    = st_last;

   // Build one result of up to two pixels from the current counts.
   assign e1   = emitted_ff + 32'd1;
   assign e2   = emitted_ff + 32'd2;
   assign r1   = rem_ff - 8'd1;
   assign r2   = rem_ff - 8'd2;
   assign over = emitted_ff >= total_ff;
   assign eq1  = e1 == total_ff;
   assign eq2  = e2 == total_ff;

   always_comb begin
      st_phase   = phase_ff;
      st_rem     = rem_ff;
      st_emitted = emitted_ff;
      st_first   = '0;
      st_second  = '0;
      st_count   = 2'd0;
      st_status  = trd_pkg::ST_OK;
      st_done    = 1'b0;
      st_last    = 1'b1;
      priority if (halted) begin
         st_status = trd_pkg::ST_IGNORED;
      end else if (over) begin
         st_status = trd_pkg::ST_TOO_MANY;
         st_phase  = trd_pkg::PH_ERROR;
      end else begin
         st_first   = pix;
         st_count   = 2'd1;
         st_emitted = e1;
         st_rem     = r1;
         priority if (r1 == '0 && eq1) begin
            st_done  = 1'b1;
            st_phase = trd_pkg::PH_DONE;
         end else if (r1 == '0) begin
            st_phase = trd_pkg::PH_HEADER;
         end else if (phase_ff != trd_pkg::PH_RUN) begin
            st_phase = trd_pkg::PH_RAW;
         end else if (eq1) begin
            // total reached inside a run: the next copy overflows
            st_status = trd_pkg::ST_TOO_MANY;
            st_phase  = trd_pkg::PH_ERROR;
         end else begin
            st_second  = pix;
            st_count   = 2'd2;
            st_emitted = e2;
            st_rem     = r2;
            priority if (r2 == '0 && eq2) begin
               st_done  = 1'b1;
               st_phase = trd_pkg::PH_DONE;
            end else if (r2 == '0) begin
               st_phase = trd_pkg::PH_HEADER;
            end else begin
               st_last = 1'b0;
            end
         end
      end
   end

   always_comb begin
      bpp_in        = bpp_ff;
      total_in      = total_ff;
      phase_in      = phase_ff;
      rem_in        = rem_ff;
      bip_in        = bip_ff;
      asm_in        = asm_ff;
      emitted_in    = emitted_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_first_in  = out_first_ff;
      out_second_in = out_second_ff;
      out_count_in  = out_count_ff;
      out_status_in = out_status_ff;
      out_done_in   = out_done_ff;
      out_last_in   = out_last_ff;

      if (csr_fire) begin
         priority case (csr_index)
            trd_pkg::CSR_BYTES_PER_PIXEL: bpp_in   = csr_data[trd_pkg::BPP_W-1:0];
            trd_pkg::CSR_PIXEL_TOTAL:     total_in = csr_data[trd_pkg::COUNT_W-1:0];
            default: begin
            end
         endcase
      end

      if (cmd.accept) begin
         priority if (req_op == trd_pkg::OP_START) begin
            phase_in   = trd_pkg::PH_HEADER;
            rem_in     = '0;
            bip_in     = '0;
            asm_in     = '0;
            emitted_in = '0;
         end else if (phase_ff == trd_pkg::PH_HEADER) begin
            if (req_data_byte < trd_pkg::RUN_THRESHOLD) begin
               phase_in = trd_pkg::PH_RAW;
               rem_in   = req_data_byte + 8'd1;
            end else begin
               phase_in = trd_pkg::PH_RUN;
               rem_in   = req_data_byte - trd_pkg::RUN_BIAS;
            end
            bip_in = '0;
            asm_in = '0;
         end else if (in_packet) begin
            asm_in = pixel_now;
            bip_in = byte_done ? 2'd0 : bip_ff + 2'd1;
         end else begin
         end
      end

      if (cmd.emit) begin
         phase_in      = st_phase;
         rem_in        = st_rem;
         emitted_in    = st_emitted;
         out_valid_in  = 1'b1;
         out_first_in  = st_first;
         out_second_in = st_second;
         out_count_in  = st_count;
         out_status_in = st_status;
         out_done_in   = st_done;
         out_last_in   = st_last;
         if (st_last) begin
            asm_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff       <= trd_pkg::BPP_RESET;
         total_ff     <= trd_pkg::TOTAL_RESET;
         phase_ff     <= trd_pkg::PH_HEADER;
         rem_ff       <= '0;
         bip_ff       <= '0;
         asm_ff       <= '0;
         emitted_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         bpp_ff       <= bpp_in;
         total_ff     <= total_in;
         phase_ff     <= phase_in;
         rem_ff       <= rem_in;
         bip_ff       <= bip_in;
         asm_ff       <= asm_in;
         emitted_ff   <= emitted_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_first_ff  <= out_first_in;
      out_second_ff <= out_second_in;
      out_count_ff  <= out_count_in;
      out_status_ff <= out_status_in;
      out_done_ff   <= out_done_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pixel_first  = out_first_ff;
   assign rsp_pixel_second = out_second_ff;
   assign rsp_pixel_count  = out_count_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_image_done   = out_done_ff;
   assign rsp_last         = out_last_ff;

endmodule

`default_nettype wire

@@ sv/trd_checker.sv @@
// Port-level checks of the decoder and their binding to the top level.
`default_nettype none

`include "tga_rle_pixel_decoder_assert.svh"

module trd_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [trd_pkg::PIXEL_W-1:0] rsp_pixel_first,
   input wire logic [trd_pkg::PIXEL_W-1:0] rsp_pixel_second,
   input wire logic [1:0]                  rsp_pixel_count,
   input wire logic [1:0]                  rsp_status,
   input wire logic                        rsp_image_done,
   input wire logic                        rsp_last
);

   // a reset leaves no result pending
   `TRD_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

   // a held result does not change under back-pressure
   `TRD_ASSERT_NEXT(a_rsp_hold, clock, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pixel_first) && $stable(rsp_pixel_second) && $stable(rsp_pixel_count) && $stable(rsp_status) && $stable(rsp_last), reset)

   // while a request still has results to come, no new request is taken
   `TRD_ASSERT_SAME(a_busy_mid_request, clock, reset, rsp_valid && !rsp_last, !req_ready)

   // the final pixel ends its request and carries at least one clean pixel
   `TRD_ASSERT_SAME(a_done_shape, clock, reset, rsp_valid && rsp_image_done, rsp_last && (rsp_status == trd_pkg::ST_OK) && (rsp_pixel_count != 2'd0))

endmodule

bind tga_rle_pixel_decoder trd_checker u_trd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_pixel_first  (rsp_ch.pixel_first),
   .rsp_pixel_second (rsp_ch.pixel_second),
   .rsp_pixel_count  (rsp_ch.pixel_count),
   .rsp_status       (rsp_ch.status),
   .rsp_image_done   (rsp_ch.image_done),
   .rsp_last         (rsp_ch.last)
);

`default_nettype wire

@@ dv/tb_tga_rle_pixel_decoder.sv @@
// Self-checking testbench of the TGA run-length pixel decoder: directed cases, then random images.
module tb_tga_rle_pixel_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   import trd_pkg::*;

   localparam int unsigned PIXELS_PER_RESULT = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 4'd15;
   localparam logic [COUNT_W-1:0] TOTAL_MAX = 32'd4294836225;
   localparam int unsigned RANDOM_REQUESTS = 130;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned TAIL_CYCLES = 16;
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned REPORT_LIMIT = 10;
   localparam int unsigned MAX_GAP = 20;

   typedef enum {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // One result of the decoder: up to two pixels plus flags.
   typedef struct {
      logic [PIXEL_W-1:0] first;
      logic [PIXEL_W-1:0] second;
      logic [1:0]         count;
      logic [1:0]         status;
      logic               done;
      logic               last;
   } pixel_pair_type;

   // Predicts the pixel pairs each request causes and checks them in order.
   class rle_scoreboard;
      logic [BPP_W-1:0]   bytes_per_pixel;
      logic [COUNT_W-1:0] pixel_total;
      phase_type          phase;
      int unsigned        remaining;
      int unsigned        byte_idx;
      logic [PIXEL_W-1:0] assembly;
      logic [COUNT_W-1:0] emitted;
      logic [PIXEL_W-1:0] pair [PIXELS_PER_RESULT];
      int unsigned        pair_n;
      pixel_pair_type     expected_pairs [$];
      int unsigned        mismatches;
      int unsigned        checked;

      function new();
         bytes_per_pixel = BPP_RESET;
         pixel_total     = TOTAL_RESET;
         phase           = PH_HEADER;
         remaining       = 0;
         byte_idx        = 0;
         assembly        = '0;
         emitted         = '0;
         pair_n          = 0;
         pair[0]         = '0;
         pair[1]         = '0;
         mismatches      = 0;
         checked         = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] data);
         if (index == CSR_BYTES_PER_PIXEL) begin
            bytes_per_pixel = data[BPP_W-1:0];
         end else if (index == CSR_PIXEL_TOTAL) begin
            pixel_total = data;
         end
      endfunction

      // Zero acts as one byte, anything above the maximum as the maximum.
      function int unsigned pixel_size();
         if (bytes_per_pixel == 0) return 1;
         if (bytes_per_pixel > MAX_BYTES_PER_PIXEL) return MAX_BYTES_PER_PIXEL;
         return bytes_per_pixel;
      endfunction

      function bit image_closed();
         return phase == PH_DONE || phase == PH_ERROR;
      endfunction

      function void push_pair(rsp_status_type status, logic done, logic last);
         pixel_pair_type p;
         p.first  = (pair_n > 0) ? pair[0] : '0;
         p.second = (pair_n > 1) ? pair[1] : '0;
         p.count  = 2'(pair_n);
         p.status = status;
         p.done   = done;
         p.last   = last;
         expected_pairs.push_back(p);
         pair_n  = 0;
         pair[0] = '0;
         pair[1] = '0;
      endfunction

      function void note_request(op_type op, logic [7:0] b);
         int unsigned    copies;
         int unsigned    left;
         int unsigned    produced;
         pixel_pair_type p;
         produced = 0;
         if (op == OP_START) begin
            phase     = PH_HEADER;
            remaining = 0;
            byte_idx  = 0;
            assembly  = '0;
            emitted   = '0;
            return;
         end
         if (image_closed()) begin
            pair_n = 0;
            push_pair(ST_IGNORED, 1'b0, 1'b1);
            return;
         end
         if (phase != PH_RAW && phase != PH_RUN) begin
            if (b < RUN_THRESHOLD) begin
               phase     = PH_RAW;
               remaining = b + 1;
            end else begin
               phase     = PH_RUN;
               remaining = b - RUN_BIAS;
            end
            byte_idx = 0;
            assembly = '0;
            return;
         end
         assembly |= PIXEL_W'(b) << (8 * byte_idx);
         if (byte_idx + 1 < pixel_size()) begin
            byte_idx = (byte_idx + 1) % MAX_BYTES_PER_PIXEL;
            return;
         end
         copies = (phase == PH_RAW) ? 1 : remaining;
         if (copies == 0) copies = 1;
         pair_n = 0;
         for (int unsigned i = 0; i < copies; i++) begin
            left = (remaining > 0) ? remaining - 1 : 0;
            if (emitted >= pixel_total) begin
               push_pair(ST_TOO_MANY, 1'b0, 1'b0);
               produced++;
               phase = PH_ERROR;
               break;
            end
            pair[pair_n] = assembly;
            pair_n++;
            emitted   = emitted + 1;
            remaining = left;
            if (left == 0 && emitted == pixel_total) begin
               push_pair(ST_OK, 1'b1, 1'b0);
               produced++;
               phase = PH_DONE;
               break;
            end
            if (pair_n == PIXELS_PER_RESULT) begin
               push_pair(ST_OK, 1'b0, 1'b0);
               produced++;
            end
            if (left == 0) break;
         end
         if (pair_n > 0) begin
            push_pair(ST_OK, 1'b0, 1'b0);
            produced++;
         end
         // A run always ends with its byte; a raw packet once its pixels are used up.
         if ((phase == PH_RAW || phase == PH_RUN) && (remaining == 0 || phase == PH_RUN)) begin
            phase     = PH_HEADER;
            remaining = 0;
         end
         byte_idx = 0;
         assembly = '0;
         if (produced > 0) begin
            p = expected_pairs.pop_back();
            p.last = 1'b1;
            expected_pairs.push_back(p);
         end
      endfunction

      function string describe(pixel_pair_type p);
         return $sformatf("first=%h second=%h count=%0d status=%0d done=%b last=%b",
                          p.first, p.second, p.count, p.status, p.done, p.last);
      endfunction

      function void check_result(pixel_pair_type got);
         pixel_pair_type want;
         if (expected_pairs.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) $display("unexpected result: %s", describe(got));
            return;
         end
         want = expected_pairs.pop_front();
         checked++;
         if (got.first !== want.first || got.second !== want.second ||
             got.count !== want.count || got.status !== want.status ||
             got.done !== want.done || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("result mismatch, expected: %s", describe(want));
               $display("                 actual:   %s", describe(got));
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   trd_req_if req_ch ();
   trd_rsp_if rsp_ch ();
   trd_csr_if csr_ch ();

   tga_rle_pixel_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   rle_scoreboard sb = new();

   int unsigned sender_idle_pct;
   int unsigned receiver_stall_pct;
   int unsigned requests_sent;
   int unsigned random_requests;
   int unsigned images;
   int unsigned cycles;
   bit          in_random;

   always #5 clock = ~clock;

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, sb.expected_pairs.size());
         $display("tb_tga_rle_pixel_decoder failed");
         $finish;
      end
   end

   // Receiver: stall at random, at the rate of the current idling phase.
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Result monitor: sample at the rising edge, check against the oldest prediction.
   always @(posedge clock) begin : result_monitor
      pixel_pair_type got;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.first  = rsp_ch.pixel_first;
         got.second = rsp_ch.pixel_second;
         got.count  = rsp_ch.pixel_count;
         got.status = rsp_ch.status;
         got.done   = rsp_ch.image_done;
         got.last   = rsp_ch.last;
         sb.check_result(got);
      end
   end

   task automatic set_idling(idle_mode_type mode);
      case (mode)
         IDLE_SENDER: begin
            sender_idle_pct    = 55;
            receiver_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 55;
         end
         IDLE_BOTH: begin
            sender_idle_pct    = 9;
            receiver_stall_pct = 9;
         end
         default: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
      endcase
   endtask

   // Offer one request and hold it until the decoder takes it. Valid stays high
   // afterwards so that back-to-back requests need no second assignment in a step.
   task automatic send_request(op_type op, logic [7:0] b);
      int unsigned gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.op        <= op;
      req_ch.data_byte <= b;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      // Count only requests that the decoder acts on, not ignored trailing bytes.
      if (in_random && (op == OP_START || !sb.image_closed())) random_requests++;
      requests_sent++;
      sb.note_request(op, b);
   endtask

   task automatic push_byte(logic [7:0] b);
      send_request(OP_DATA, b);
   endtask

   // Drop valid, drain every predicted result, then let any result-free request finish.
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.expected_pairs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      @(posedge clock);
      while (csr_ch.ready !== 1'b1) @(posedge clock);
      sb.write_register(index, data);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // One random image: program the registers, start, then mostly well-formed
   // packets with random pixel bytes, sprinkled with stray bytes and restarts.
   task automatic run_image(idle_mode_type mode);
      logic [BPP_W-1:0]   bpp;
      logic [COUNT_W-1:0] total;
      int unsigned        pick;
      int unsigned        size;
      int unsigned        count;
      int unsigned        n_bytes;
      int unsigned        stop_at;
      bit                 raw;
      settle();
      set_idling(mode);
      pick = $urandom_range(9);
      bpp = (pick == 0) ? 3'd0 : (pick == 1) ? 3'd7
                        : 3'($urandom_range(1, MAX_BYTES_PER_PIXEL));
      pick = $urandom_range(9);
      total = (pick == 0) ? '0 : (pick == 1) ? TOTAL_MAX : COUNT_W'($urandom_range(1, 24));
      // Upper data bits beyond the register width must be dropped.
      write_csr(CSR_BYTES_PER_PIXEL, ($urandom() & ~32'h7) | CSR_DATA_W'(bpp));
      write_csr(CSR_PIXEL_TOTAL, total);
      images++;
      send_request(OP_START, 8'($urandom()));
      size    = sb.pixel_size();
      stop_at = random_requests + $urandom_range(12, 48);
      while (random_requests < stop_at && !sb.image_closed()) begin
         pick = $urandom_range(99);
         if (pick < 4) begin
            send_request(OP_START, 8'($urandom()));
         end else if (pick < 12) begin
            push_byte(8'($urandom()));
         end else begin
            raw   = $urandom_range(1);
            count = ($urandom_range(15) == 0 && (!raw || size == 1))
                    ? $urandom_range(1, 128) : $urandom_range(1, 4);
            push_byte(raw ? 8'(count - 1) : 8'(count + RUN_BIAS));
            n_bytes = raw ? count * size : size;
            for (int unsigned k = 0; k < n_bytes && !sb.image_closed(); k++) begin
               push_byte(8'($urandom()));
            end
         end
      end
      // Stray bytes after done or an error must each come back flagged.
      if (sb.image_closed()) begin
         repeat ($urandom_range(0, 2)) push_byte(8'($urandom()));
      end
   endtask

   initial begin
      req_ch.valid     = 1'b0;
      req_ch.op        = OP_DATA;
      req_ch.data_byte = '0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = '0;
      csr_ch.data      = '0;
      rsp_ch.ready     = 1'b0;
      reset            = 1'b1;
      in_random        = 1'b0;
      set_idling(IDLE_NONE);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Single-byte pixels: a run of two pairs up, a raw packet lands exactly on
      // the total for done, then a byte after done is flagged. Also poke an
      // index past the register list, which must change nothing.
      settle();
      write_csr(CSR_BYTES_PER_PIXEL, 32'd1);
      write_csr(CSR_PIXEL_TOTAL, 32'd4);
      write_csr(CSR_UNMAPPED, 32'hFFFF_FFFF);
      send_request(OP_START, 8'hFF);
      push_byte(8'h81);
      push_byte(8'hFF);
      push_byte(8'h01);
      push_byte(8'h00);
      push_byte(8'h80);
      push_byte(8'h7F);

      // Two-byte pixels: the run overshoots the total with one pixel pending, so
      // the too-many result still carries it.
      settle();
      write_csr(CSR_BYTES_PER_PIXEL, 32'd2);
      write_csr(CSR_PIXEL_TOTAL, 32'd2);
      send_request(OP_START, 8'h00);
      push_byte(8'h80);
      push_byte(8'h01);
      push_byte(8'h02);
      push_byte(8'h83);
      push_byte(8'h03);
      push_byte(8'h04);

      // Longest raw packet: the total is reached inside it, so no done, and the
      // next pixel of the packet is the error.
      settle();
      write_csr(CSR_BYTES_PER_PIXEL, 32'd1);
      write_csr(CSR_PIXEL_TOTAL, 32'd2);
      send_request(OP_START, 8'h00);
      push_byte(8'h7F);
      push_byte(8'hAA);
      push_byte(8'h55);
      push_byte(8'h01);

      // Zero total: the very first pixel is already too many.
      settle();
      write_csr(CSR_PIXEL_TOTAL, 32'd0);
      send_request(OP_START, 8'h00);
      push_byte(8'h80);
      push_byte(8'h33);

      // Oversized pixel setting acts as four bytes; longest run gives 64 pairs.
      settle();
      write_csr(CSR_BYTES_PER_PIXEL, 32'd7);
      write_csr(CSR_PIXEL_TOTAL, TOTAL_MAX);
      send_request(OP_START, 8'h00);
      push_byte(8'hFF);
      push_byte(8'hDE);
      push_byte(8'hAD);
      push_byte(8'hBE);
      push_byte(8'hEF);

      // Shrink the pixel size mid pixel: the third byte completes it at once.
      push_byte(8'h00);
      push_byte(8'h11);
      push_byte(8'h22);
      settle();
      write_csr(CSR_BYTES_PER_PIXEL, 32'd2);
      push_byte(8'h33);

      // Random images, cycling through the idling phases.
      in_random = 1'b1;
      while (random_requests < RANDOM_REQUESTS) begin
         run_image(idle_mode_type'(images % 4));
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d requests sent (%0d in %0d random images), %0d results checked",
               requests_sent, random_requests, images, sb.checked);
      $display("idling: none, sender 55%%, receiver 55%%, both 9%%; %0d mismatches",
               sb.mismatches);
      if (sb.expected_pairs.size() != 0) begin
         $display("%0d predicted results never arrived", sb.expected_pairs.size());
      end
      if (sb.mismatches == 0 && sb.expected_pairs.size() == 0) begin
         $display("tb_tga_rle_pixel_decoder passed");
      end else begin
         $display("tb_tga_rle_pixel_decoder failed");
      end
      $finish;
   end

endmodule
